// ===== design/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, character codes and helper functions of the JSON string
// escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int unsigned MAX_OUT = 6;
    localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);

    typedef logic [MAX_OUT-1:0][7:0] t_bytes;
    typedef logic [CNT_W-1:0]        t_cnt;

    // open utf-8 sequence
    typedef struct packed {
        logic [7:0]  lead;
        logic [23:0] tail;
        logic [1:0]  held;
        logic [1:0]  needed;
    } t_seq;

    // register indexes
    localparam logic REG_QUOTE = 1'b0;

    localparam logic [7:0] QUOTE_RST = 8'h22;

    // character codes
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_D_UP  = 8'h44;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    // lower-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = CH_ZERO + {4'h0, d};
        end else begin
            r = 8'h57 + {4'h0, d};
        end
        return r;
    endfunction

    // escape letter for 0x08..0x0d
    function automatic logic [7:0] ctl_letter(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h62; // b
            3'd1:    r = 8'h74; // t
            3'd2:    r = 8'h6e; // n
            3'd3:    r = 8'h76; // v
            3'd4:    r = 8'h66; // f
            3'd5:    r = 8'h72; // r
            default: r = 8'h3f;
        endcase
        return r;
    endfunction

endpackage

// ===== design/jse_encode.sv =====
// ----------------------------------------------------------------------------
// jse_encode
// Maps one input byte and the open utf-8 sequence to up to six escaped
// output bytes and the next sequence state.
// ----------------------------------------------------------------------------
module jse_encode (
    input  logic [7:0]      i_byte,
    input  logic            i_eos,
    input  logic [7:0]      i_quote,
    input  jse_pkg::t_seq   i_seq,
    output jse_pkg::t_bytes o_bytes,
    output jse_pkg::t_cnt   o_cnt,
    output jse_pkg::t_seq   o_seq
);

    localparam logic [7:0] CH_BSL_L = jse_pkg::CH_BSL;

    logic [23:0] tail_n;
    logic [1:0]  held_n;
    logic [1:0]  needed_n;
    logic        bad;
    logic [20:0] val;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [7:0]  c3;
    logic [7:0]  ctl_off;

    assign ctl_off = i_byte - 8'h08;

    always_comb begin
        tail_n = i_seq.tail;
        case (i_seq.held)
            2'd0:    tail_n[7:0]   = i_byte;
            2'd1:    tail_n[15:8]  = i_byte;
            2'd2:    tail_n[23:16] = i_byte;
            default: tail_n = i_seq.tail;
        endcase
        held_n   = i_seq.held + 2'd1;
        needed_n = i_seq.needed - 2'd1;
        c1 = tail_n[7:0];
        c2 = tail_n[15:8];
        c3 = tail_n[23:16];

        bad = (c1[7:6] != 2'b10);
        if (held_n >= 2'd2 && c2[7:6] != 2'b10) bad = 1'b1;
        if (held_n == 2'd3 && c3[7:6] != 2'b10) bad = 1'b1;
        case (held_n)
            2'd1:    val = {10'h000, i_seq.lead[4:0], c1[5:0]};
            2'd2:    val = {5'h00, i_seq.lead[3:0], c1[5:0], c2[5:0]};
            default: val = {i_seq.lead[2:0], c1[5:0], c2[5:0], c3[5:0]};
        endcase
        // above the basic plane
        if (held_n != 2'd1 && held_n != 2'd2 && val[20:16] != 5'h00) bad = 1'b1;
    end

    always_comb begin
        o_bytes = '0;
        o_cnt   = '0;
        o_seq   = i_seq;
        if (i_seq.needed != 2'd0) begin
            o_seq.tail   = tail_n;
            o_seq.held   = held_n;
            o_seq.needed = needed_n;
            if (needed_n == 2'd0) begin
                o_bytes[0] = CH_BSL_L;
                o_bytes[1] = jse_pkg::CH_U;
                if (bad) begin
                    o_bytes[2] = jse_pkg::CH_F_UP;
                    o_bytes[3] = jse_pkg::CH_F_UP;
                    o_bytes[4] = jse_pkg::CH_F_UP;
                    o_bytes[5] = jse_pkg::CH_D_UP;
                end else begin
                    o_bytes[2] = jse_pkg::hex_char(val[15:12]);
                    o_bytes[3] = jse_pkg::hex_char(val[11:8]);
                    o_bytes[4] = jse_pkg::hex_char(val[7:4]);
                    o_bytes[5] = jse_pkg::hex_char(val[3:0]);
                end
                o_cnt = jse_pkg::t_cnt'(jse_pkg::MAX_OUT);
                o_seq = '0;
            end else if (i_eos) begin
                // cut short: lead and collected bytes go out raw
                o_bytes[0] = i_seq.lead;
                o_bytes[1] = tail_n[7:0];
                o_bytes[2] = tail_n[15:8];
                o_cnt      = jse_pkg::t_cnt'(held_n) + jse_pkg::t_cnt'(1);
            end
        end else if (i_byte == 8'h00) begin
            o_bytes[0] = CH_BSL_L;
            o_bytes[1] = jse_pkg::CH_ZERO;
            o_cnt      = jse_pkg::t_cnt'(2);
        end else if (i_byte inside {[8'h08:8'h0d]}) begin
            o_bytes[0] = CH_BSL_L;
            o_bytes[1] = jse_pkg::ctl_letter(ctl_off[2:0]);
            o_cnt      = jse_pkg::t_cnt'(2);
        end else if (i_byte < 8'h20 || i_byte == jse_pkg::CH_DEL) begin
            o_bytes[0] = CH_BSL_L;
            o_bytes[1] = jse_pkg::CH_X;
            o_bytes[2] = jse_pkg::hex_char(i_byte[7:4]);
            o_bytes[3] = jse_pkg::hex_char(i_byte[3:0]);
            o_cnt      = jse_pkg::t_cnt'(4);
        end else if (i_byte == CH_BSL_L) begin
            o_bytes[0] = CH_BSL_L;
            o_bytes[1] = CH_BSL_L;
            o_cnt      = jse_pkg::t_cnt'(2);
        end else if ((i_byte == jse_pkg::CH_DQUOT || i_byte == jse_pkg::CH_SQUOT)
                     && i_byte == i_quote) begin
            o_bytes[0] = CH_BSL_L;
            o_bytes[1] = i_byte;
            o_cnt      = jse_pkg::t_cnt'(2);
        end else if (i_byte < 8'h80) begin
            o_bytes[0] = i_byte;
            o_cnt      = jse_pkg::t_cnt'(1);
        end else if (i_byte < 8'hc0 || i_byte >= 8'hf8) begin
            o_bytes[0] = CH_BSL_L;
            o_bytes[1] = jse_pkg::CH_U;
            o_bytes[2] = jse_pkg::CH_F_UP;
            o_bytes[3] = jse_pkg::CH_F_UP;
            o_bytes[4] = jse_pkg::CH_F_UP;
            o_bytes[5] = jse_pkg::CH_D_UP;
            o_cnt      = jse_pkg::t_cnt'(jse_pkg::MAX_OUT);
        end else if (i_eos) begin
            // lone lead byte at end of string
            o_bytes[0] = i_byte;
            o_cnt      = jse_pkg::t_cnt'(1);
        end else begin
            o_seq.lead = i_byte;
            o_seq.tail = '0;
            o_seq.held = 2'd0;
            if (i_byte < 8'he0) begin
                o_seq.needed = 2'd1;
            end else if (i_byte < 8'hf0) begin
                o_seq.needed = 2'd2;
            end else begin
                o_seq.needed = 2'd3;
            end
        end
        if (i_eos) o_seq = '0;
    end

endmodule

// ===== design/jse_outbuf.sv =====
// ----------------------------------------------------------------------------
// jse_outbuf
// Result register: holds the escaped bytes of one input byte and shifts
// them out one word per handshake.
// ----------------------------------------------------------------------------
module jse_outbuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  jse_pkg::t_bytes i_bytes,
    input  jse_pkg::t_cnt   i_cnt,
    input  logic            i_tready,
    output logic            o_tvalid,
    output logic [7:0]      o_tdata,
    output logic            o_tlast,
    output logic            o_free
);

    jse_pkg::t_cnt   r_cnt;
    jse_pkg::t_bytes r_buf;
    logic            pop;

    assign o_tvalid = (r_cnt != '0);
    assign o_tdata  = r_buf[0];
    assign o_tlast  = (r_cnt == jse_pkg::t_cnt'(1));
    assign pop      = o_tvalid && i_tready;
    // free now or after the last word leaves this cycle
    assign o_free   = !o_tvalid || (o_tlast && i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - jse_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_bytes;
        end else if (pop) begin
            r_buf <= r_buf >> 8;
        end
    end

endmodule

// ===== design/json_string_escaper_core.sv =====
// ----------------------------------------------------------------------------
// json_string_escaper_core
// Escapes string bytes for a JSON string literal, folding utf-8 sequences
// into \uxxxx escapes.
//
//   port group      dir  fields (lsb first)
//   s_t*            in   tdata: in_byte[7:0]; tlast: end_of_string
//   m_t*            out  tdata: out_byte[7:0]; tlast: run_last
//   p* (apb)        in   0x0: quote_byte[7:0]
//
// an input byte is registered, escaped combinationally and loaded into a six
// byte result register once that register is free. one output word per cycle
// while m_tready is high; a byte that yields several words holds the result
// register until its last word leaves, so input runs at one byte per cycle only
// while each byte escapes to a single word. lead and middle continuation
// bytes that do not end the string produce nothing and never wait for the
// result register. reset is synchronous, clears the open sequence and sets the
// quote register to a double quote.
// ----------------------------------------------------------------------------
module json_string_escaper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            r_in_vld;
    logic [7:0]      r_in_byte;
    logic            r_in_eos;
    jse_pkg::t_seq   r_seq;
    jse_pkg::t_seq   n_seq;
    logic [7:0]      r_quote;
    jse_pkg::t_bytes enc_bytes;
    jse_pkg::t_cnt   enc_cnt;
    logic            buf_free;
    logic            advance;
    logic            accept;

    jse_encode u_enc (
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .i_quote (r_quote),
        .i_seq   (r_seq),
        .o_bytes (enc_bytes),
        .o_cnt   (enc_cnt),
        .o_seq   (n_seq)
    );

    jse_outbuf u_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && enc_cnt != '0),
        .i_bytes  (enc_bytes),
        .i_cnt    (enc_cnt),
        .i_tready (m_tready),
        .o_tvalid (m_tvalid),
        .o_tdata  (m_tdata),
        .o_tlast  (m_tlast),
        .o_free   (buf_free)
    );

    // silent bytes advance even while the result register is busy
    assign advance  = r_in_vld && (enc_cnt == '0 || buf_free);
    assign s_tready = !r_in_vld || advance;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_seq    <= '0;
        end else begin
            r_in_vld <= accept || (r_in_vld && !advance);
            if (advance) r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= s_tdata;
            r_in_eos  <= s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote <= jse_pkg::QUOTE_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == jse_pkg::REG_QUOTE) begin
            r_quote <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == jse_pkg::REG_QUOTE) ? {24'h000000, r_quote} : 32'h0;

endmodule

// ===== design/jse_checker.sv =====
// ----------------------------------------------------------------------------
// jse_checker
// Port-level checks of the JSON string escaper, bound to the top level.
// ----------------------------------------------------------------------------
module jse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // with nothing pending at the output the input side never blocks
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty result register");

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid right after reset");

    // the quote register reads back what was written
    a_quote_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr[2] == jse_pkg::REG_QUOTE
        ##1 psel && !pwrite && paddr[2] == jse_pkg::REG_QUOTE
        |-> prdata == {24'h000000, $past(pwdata[7:0])})
        else $error("quote register readback mismatch");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);
